// File: rtl/hepg_pkg.sv
package hepg_pkg;

    localparam int TIME_WIDTH_DEF  = 48;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int FLOOR_SHIFT_DEF = 3;

    localparam int CFG_IDX_WIDTH = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_INIT_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GATE_MULT    = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_GAP      = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RESYNC_THR   = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_JITTER_SHIFT = 3'd4;

    localparam int         INIT_PERIOD_RST = 50000;
    localparam logic [3:0] GATE_MULT_RST   = 4'd5;
    localparam logic [3:0] MAX_GAP_RST     = 4'd8;
    localparam logic [2:0] RESYNC_THR_RST  = 3'd2;
    localparam logic [2:0] JITTER_SHIFT_RST = 3'd2;

    localparam logic [3:0] CLS_SEED    = 4'd0;
    localparam logic [3:0] CLS_FIRST   = 4'd1;
    localparam logic [3:0] CLS_NORMAL  = 4'd2;
    localparam logic [3:0] CLS_MISSED  = 4'd3;
    localparam logic [3:0] CLS_SPUR    = 4'd4;
    localparam logic [3:0] CLS_OUTLIER = 4'd5;
    localparam logic [3:0] CLS_STALL   = 4'd6;
    localparam logic [3:0] CLS_RESYNC  = 4'd7;
    localparam logic [3:0] CLS_NONMONO = 4'd8;

    localparam logic [3:0] REVS_SAT = 4'd15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DIV_Q_GO,
        ST_DIV_Q_WAIT,
        ST_ROUND,
        ST_GATE,
        ST_DECIDE,
        ST_DIV_P_GO,
        ST_DIV_P_WAIT,
        ST_DIV_J_GO,
        ST_DIV_J_WAIT,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// File: rtl/hall_edge_period_gate_unit.sv
// path: seed, first measurement and non-monotonic edges skip the divider; gap stall,
// gap resync, spurious, outlier and gate resync edges use one division, fitting edges three;
// a held result waits for o_m_tready
// throughput: one edge at a time, set by the one-bit-per-cycle shared divider
// that runs up to three divisions per edge; next request taken once the result is registered
// reset: synchronous active low, restores register defaults and the filter start state
module hall_edge_period_gate_unit #(
    parameter int TIME_WIDTH  = hepg_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = hepg_pkg::COUNT_WIDTH_DEF,
    parameter int FLOOR_SHIFT = hepg_pkg::FLOOR_SHIFT_DEF,
    parameter int IN_W  = ((TIME_WIDTH + 7) / 8) * 8,
    parameter int OUT_W = (((2 * TIME_WIDTH + 4 + 7 * COUNT_WIDTH) + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // edge_time
    input  logic [IN_W-1:0]                    i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // period_estimate, jitter_estimate, implied_revolutions, accepted_total,
    // spurious_total, missed_events, missed_pulse_sum, outlier_total,
    // stall_total, resync_total
    output logic [OUT_W-1:0]                   o_m_tdata,
    // edge_taken, edge_class
    output logic [4:0]                         o_m_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hepg_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [TIME_WIDTH-1:0]              i_cfg_data
);
    import hepg_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int GW = TW + 4;

    t_state r_state, n_state;

    logic [TW-1:0] r_init_period;
    logic [3:0]    r_gate_mult;
    logic [3:0]    r_max_gap;
    logic [2:0]    r_resync_thr;
    logic [2:0]    r_jit_shift;

    logic [TW-1:0] r_last, n_last;
    logic [TW-1:0] r_period, n_period;
    logic [TW-1:0] r_jitter, n_jitter;
    logic          r_started, n_started;
    logic          r_measured, n_measured;
    logic [2:0]    r_streak, n_streak;
    logic [CW-1:0] r_acc, n_acc;
    logic [CW-1:0] r_spur, n_spur;
    logic [CW-1:0] r_miss, n_miss;
    logic [CW-1:0] r_mpulse, n_mpulse;
    logic [CW-1:0] r_outl, n_outl;
    logic [CW-1:0] r_stall, n_stall;
    logic [CW-1:0] r_resync, n_resync;

    logic [TW-1:0] r_edge, n_edge;
    logic [TW-1:0] r_elapsed, n_elapsed;
    logic [TW-1:0] r_q, n_q;
    logic [TW-1:0] r_r, n_r;
    logic [TW-1:0] r_n, n_n;
    logic [TW-1:0] r_abs, n_abs;
    logic [GW-1:0] r_gate, n_gate;
    logic [TW-1:0] r_sp, n_sp;
    logic [3:0]    r_revs, n_revs;
    logic [3:0]    r_cls, n_cls;
    logic          r_taken, n_taken;

    logic          r_o_valid, n_o_valid;
    logic [OUT_W-1:0] r_o_data, n_o_data;
    logic [4:0]    r_o_user, n_o_user;

    logic          div_start;
    logic [TW-1:0] div_dividend, div_divisor, div_quo, div_rem;
    t_div_status   div_st;

    logic [TW-1:0] seed_period;
    logic [TW-1:0] half_up, nn, d_jit, low_mask;
    logic [2:0]    s_next;
    logic          resync_hit;
    logic [GW-1:0] gate_eff, floor_gate;

    assign seed_period = (r_init_period != '0) ? r_init_period : TW'(1);

    hepg_div #(.W(TW)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_status    (div_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_init_period <= TW'(INIT_PERIOD_RST);
            r_gate_mult   <= GATE_MULT_RST;
            r_max_gap     <= MAX_GAP_RST;
            r_resync_thr  <= RESYNC_THR_RST;
            r_jit_shift   <= JITTER_SHIFT_RST;
            r_last        <= '0;
            r_period      <= TW'(INIT_PERIOD_RST);
            r_jitter      <= '0;
            r_started     <= 1'b0;
            r_measured    <= 1'b0;
            r_streak      <= '0;
            r_acc         <= '0;
            r_spur        <= '0;
            r_miss        <= '0;
            r_mpulse      <= '0;
            r_outl        <= '0;
            r_stall       <= '0;
            r_resync      <= '0;
            r_o_valid     <= 1'b0;
        end else if (i_cfg_valid) begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            case (i_cfg_index)
                REG_INIT_PERIOD: begin
                    r_init_period <= i_cfg_data;
                    r_last        <= '0;
                    r_period      <= (i_cfg_data != '0) ? i_cfg_data : TW'(1);
                    r_jitter      <= '0;
                    r_started     <= 1'b0;
                    r_measured    <= 1'b0;
                    r_streak      <= '0;
                    r_acc         <= '0;
                    r_spur        <= '0;
                    r_miss        <= '0;
                    r_mpulse      <= '0;
                    r_outl        <= '0;
                    r_stall       <= '0;
                    r_resync      <= '0;
                end
                REG_GATE_MULT:    r_gate_mult  <= i_cfg_data[3:0];
                REG_MAX_GAP:      r_max_gap    <= i_cfg_data[3:0];
                REG_RESYNC_THR:   r_resync_thr <= i_cfg_data[2:0];
                REG_JITTER_SHIFT: r_jit_shift  <= i_cfg_data[2:0];
                default: ;
            endcase
        end else begin
            r_state    <= n_state;
            r_last     <= n_last;
            r_period   <= n_period;
            r_jitter   <= n_jitter;
            r_started  <= n_started;
            r_measured <= n_measured;
            r_streak   <= n_streak;
            r_acc      <= n_acc;
            r_spur     <= n_spur;
            r_miss     <= n_miss;
            r_mpulse   <= n_mpulse;
            r_outl     <= n_outl;
            r_stall    <= n_stall;
            r_resync   <= n_resync;
            r_o_valid  <= n_o_valid;
        end
        r_edge    <= n_edge;
        r_elapsed <= n_elapsed;
        r_q       <= n_q;
        r_r       <= n_r;
        r_n       <= n_n;
        r_abs     <= n_abs;
        r_gate    <= n_gate;
        r_sp      <= n_sp;
        r_revs    <= n_revs;
        r_cls     <= n_cls;
        r_taken   <= n_taken;
        r_o_data  <= n_o_data;
        r_o_user  <= n_o_user;
    end

    always_comb begin
        n_state    = r_state;
        n_last     = r_last;
        n_period   = r_period;
        n_jitter   = r_jitter;
        n_started  = r_started;
        n_measured = r_measured;
        n_streak   = r_streak;
        n_acc      = r_acc;
        n_spur     = r_spur;
        n_miss     = r_miss;
        n_mpulse   = r_mpulse;
        n_outl     = r_outl;
        n_stall    = r_stall;
        n_resync   = r_resync;
        n_edge     = r_edge;
        n_elapsed  = r_elapsed;
        n_q        = r_q;
        n_r        = r_r;
        n_n        = r_n;
        n_abs      = r_abs;
        n_gate     = r_gate;
        n_sp       = r_sp;
        n_revs     = r_revs;
        n_cls      = r_cls;
        n_taken    = r_taken;
        n_o_valid  = r_o_valid & ~i_m_tready;
        n_o_data   = r_o_data;
        n_o_user   = r_o_user;

        div_start    = 1'b0;
        div_dividend = r_elapsed;
        div_divisor  = r_period;

        half_up    = r_period - (r_period >> 1);
        nn         = r_q + ((r_r >= half_up) ? TW'(1) : TW'(0));
        s_next     = r_streak + 3'd1;
        resync_hit = (s_next >= r_resync_thr);
        floor_gate = GW'(r_period >> FLOOR_SHIFT);
        gate_eff   = (r_gate < floor_gate) ? floor_gate : r_gate;
        low_mask   = (TW'(1) << r_jit_shift) - TW'(1);
        d_jit      = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_edge  = i_s_tdata[TW-1:0];
                    n_revs  = '0;
                    n_taken = 1'b1;
                    n_state = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                n_elapsed = r_edge - r_last;
                if (!r_started) begin
                    n_last    = r_edge;
                    n_started = 1'b1;
                    n_streak  = '0;
                    n_acc     = r_acc + 1'b1;
                    n_cls     = CLS_SEED;
                    n_state   = ST_OUT;
                end else if (r_edge <= r_last || r_period == '0) begin
                    n_last  = r_edge;
                    n_stall = r_stall + 1'b1;
                    n_cls   = CLS_NONMONO;
                    n_state = ST_OUT;
                end else if (!r_measured) begin
                    n_last     = r_edge;
                    n_period   = r_edge - r_last;
                    n_jitter   = '0;
                    n_streak   = '0;
                    n_acc      = r_acc + 1'b1;
                    n_measured = 1'b1;
                    n_cls      = CLS_FIRST;
                    n_state    = ST_OUT;
                end else begin
                    n_state = ST_DIV_Q_GO;
                end
            end
            ST_DIV_Q_GO: begin
                div_start = 1'b1;
                n_state   = ST_DIV_Q_WAIT;
            end
            ST_DIV_Q_WAIT: begin
                if (div_st.done) begin
                    n_q     = div_quo;
                    n_r     = div_rem;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_n     = (nn == '0) ? TW'(1) : nn;
                n_revs  = (nn > TW'(REVS_SAT)) ? REVS_SAT :
                          ((nn == '0) ? 4'd1 : nn[3:0]);
                n_state = ST_GATE;
            end
            ST_GATE: begin
                n_abs   = (r_n == r_q && r_q != '0) ? r_r : r_period - r_r;
                n_gate  = GW'(r_gate_mult) * GW'(r_jitter);
                n_state = ST_DECIDE;
                if (r_n > TW'(r_max_gap)) begin
                    n_state = ST_OUT;
                    if (resync_hit) begin
                        n_last   = r_edge;
                        n_period = r_elapsed;
                        n_jitter = '0;
                        n_streak = '0;
                        n_acc    = r_acc + 1'b1;
                        n_resync = r_resync + 1'b1;
                        n_cls    = CLS_RESYNC;
                    end else begin
                        n_streak = s_next;
                        n_last   = r_edge;
                        n_stall  = r_stall + 1'b1;
                        n_cls    = CLS_STALL;
                    end
                end
            end
            ST_DECIDE: begin
                if (GW'(r_abs) >= gate_eff) begin
                    n_state = ST_OUT;
                    if (resync_hit) begin
                        n_last   = r_edge;
                        n_period = r_elapsed;
                        n_jitter = '0;
                        n_streak = '0;
                        n_acc    = r_acc + 1'b1;
                        n_resync = r_resync + 1'b1;
                        n_cls    = CLS_RESYNC;
                    end else if (r_elapsed < (r_period >> 1) && r_streak == '0) begin
                        n_streak = s_next;
                        n_spur   = r_spur + 1'b1;
                        n_taken  = 1'b0;
                        n_cls    = CLS_SPUR;
                    end else begin
                        n_streak = s_next;
                        n_last   = r_edge;
                        n_outl   = r_outl + 1'b1;
                        n_cls    = CLS_OUTLIER;
                    end
                end else begin
                    n_state = ST_DIV_P_GO;
                end
            end
            ST_DIV_P_GO: begin
                div_start    = 1'b1;
                div_dividend = r_elapsed;
                div_divisor  = r_n;
                n_state      = ST_DIV_P_WAIT;
            end
            ST_DIV_P_WAIT: begin
                if (div_st.done) begin
                    n_sp    = div_quo;
                    n_state = ST_DIV_J_GO;
                end
            end
            ST_DIV_J_GO: begin
                div_start    = 1'b1;
                div_dividend = r_abs;
                div_divisor  = r_n;
                n_state      = ST_DIV_J_WAIT;
            end
            ST_DIV_J_WAIT: begin
                if (div_st.done) begin
                    n_q     = div_quo;
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_last   = r_edge;
                n_period = r_sp;
                if (r_q >= r_jitter) begin
                    n_jitter = r_jitter + ((r_q - r_jitter) >> r_jit_shift);
                end else begin
                    d_jit    = r_jitter - r_q;
                    n_jitter = r_jitter - (d_jit >> r_jit_shift)
                               - (((d_jit & low_mask) != '0) ? TW'(1) : TW'(0));
                end
                n_streak = '0;
                n_acc    = r_acc + 1'b1;
                if (r_n > TW'(1)) begin
                    n_miss   = r_miss + 1'b1;
                    n_mpulse = r_mpulse + CW'(r_n - TW'(1));
                    n_cls    = CLS_MISSED;
                end else begin
                    n_cls    = CLS_NORMAL;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_o_valid || i_m_tready) begin
                    n_o_valid = 1'b1;
                    n_o_data  = OUT_W'({r_resync, r_stall, r_outl, r_mpulse, r_miss,
                                        r_spur, r_acc, r_revs, r_jitter, r_period});
                    n_o_user  = {r_cls, r_taken};
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_o_valid;
    assign o_m_tdata   = r_o_data;
    assign o_m_tuser   = r_o_user;
    assign o_cfg_ready = 1'b1;

    property p_accept_goes_classify;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_cfg_valid) |=> (r_state == ST_CLASSIFY);
    endproperty
    a_accept_goes_classify: assert property (p_accept_goes_classify)
        else $error("accepted edge not classified");

    property p_measured_needs_started;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_measured |-> r_started;
    endproperty
    a_measured_needs_started: assert property (p_measured_needs_started)
        else $error("measured without seed");

    property p_div_done_in_wait;
        @(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == ST_DIV_Q_WAIT || r_state == ST_DIV_P_WAIT ||
                         r_state == ST_DIV_J_WAIT);
    endproperty
    a_div_done_in_wait: assert property (p_div_done_in_wait)
        else $error("divider result outside wait state");

    property p_out_sets_valid;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !r_o_valid && !i_cfg_valid) |=> r_o_valid;
    endproperty
    a_out_sets_valid: assert property (p_out_sets_valid)
        else $error("result not presented");

endmodule

// File: rtl/hepg_div.sv
module hepg_div #(
    parameter int W = hepg_pkg::TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_dividend,
    input  logic [W-1:0]          i_divisor,
    output logic [W-1:0]          o_quotient,
    output logic [W-1:0]          o_remainder,
    output hepg_pkg::t_div_status o_status
);
    import hepg_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_dsr, n_dsr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [W:0]       trial;
    logic [W:0]       diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    always_comb begin
        trial  = {r_rem, r_quo[W-1]};
        diff   = trial - {1'b0, r_dsr};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = '0;
            n_quo = i_dividend;
            n_dsr = i_divisor;
            n_cnt = CNT_W'(W);
        end else if (r_cnt != '0) begin
            if (!diff[W]) begin
                n_rem = diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_done = 1'b1;
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_status.busy = (r_cnt != '0);
    assign o_status.done = r_done;

    property p_done_after_last_step;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_W'(1) && !i_start) |=> r_done;
    endproperty
    a_done_after_last_step: assert property (p_done_after_last_step)
        else $error("divider done missing");

    property p_done_not_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_cnt == '0 || $past(i_start));
    endproperty
    a_done_not_busy: assert property (p_done_not_busy)
        else $error("divider done while busy");

    property p_start_loads_count;
        @(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_cnt == CNT_W'(W));
    endproperty
    a_start_loads_count: assert property (p_start_loads_count)
        else $error("divider count not loaded");

endmodule

// File: sim/hepg_checker.sv
`timescale 1ns / 1ps
module hepg_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [47:0]  i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [327:0] i_m_tdata,
    input  logic [4:0]   i_m_tuser,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending
);
    import hepg_pkg::*;

    typedef struct packed {
        logic        taken;
        logic [3:0]  cls;
        logic [47:0] period;
        logic [47:0] jitter;
        logic [3:0]  revs;
        logic [31:0] acc, spur, miss, mpulse, outl, stall, resync;
    } t_edge_result;

    t_edge_result expected_results[$];

    logic [47:0] init_period;
    logic [3:0]  gate_mult, max_gap;
    logic [2:0]  resync_thr, jit_shift;
    logic [47:0] last_edge, period_q, jitter_q;
    logic        started, measured;
    logic [2:0]  streak;
    logic [31:0] acc_c, spur_c, miss_c, mpulse_c, outl_c, stall_c, resync_c;

    task automatic reseed_filter();
        last_edge = '0;
        period_q  = (init_period != 0) ? init_period : 48'd1;
        jitter_q  = '0;
        started   = 0;
        measured  = 0;
        streak    = 0;
        acc_c = 0; spur_c = 0; miss_c = 0; mpulse_c = 0;
        outl_c = 0; stall_c = 0; resync_c = 0;
    endtask

    function automatic bit streak_resync(logic [47:0] e, logic [47:0] el);
        logic [2:0] s;
        s = streak + 3'd1;
        if (s < resync_thr) begin
            streak = s;
            return 0;
        end
        last_edge = e;
        period_q  = el;
        jitter_q  = 0;
        streak    = 0;
        acc_c++;
        resync_c++;
        return 1;
    endfunction

    function automatic t_edge_result classify_edge(logic [47:0] e);
        t_edge_result r;
        logic [63:0] el, p, q, rm, n, fl, gate, ares, sp, sj, d, lowb;
        logic [2:0] sh;
        bit early, iso;
        r = '0;
        r.taken = 1;
        r.cls = CLS_SEED;
        if (!started) begin
            last_edge = e;
            started = 1;
            streak = 0;
            acc_c++;
        end else if (e <= last_edge || period_q == 0) begin
            last_edge = e;
            stall_c++;
            r.cls = CLS_NONMONO;
        end else if (!measured) begin
            period_q = e - last_edge;
            last_edge = e;
            jitter_q = 0;
            streak = 0;
            acc_c++;
            measured = 1;
            r.cls = CLS_FIRST;
        end else begin
            el = e - last_edge;
            p  = period_q;
            q  = el / p;
            rm = el % p;
            n  = q + ((rm >= p - (p >> 1)) ? 1 : 0);
            if (n < 1) n = 1;
            r.revs = (n > 15) ? REVS_SAT : n[3:0];
            if (n > max_gap) begin
                if (streak_resync(e, el[47:0])) r.cls = CLS_RESYNC;
                else begin
                    last_edge = e;
                    stall_c++;
                    r.cls = CLS_STALL;
                end
            end else begin
                fl   = p >> FLOOR_SHIFT_DEF;
                ares = (n == q && q != 0) ? rm : p - rm;
                gate = gate_mult * {16'd0, jitter_q};
                if (gate < fl) gate = fl;
                if (ares >= gate) begin
                    early = el < (p >> 1);
                    iso = streak == 0;
                    if (streak_resync(e, el[47:0])) r.cls = CLS_RESYNC;
                    else if (early && iso) begin
                        spur_c++;
                        r.taken = 0;
                        r.cls = CLS_SPUR;
                    end else begin
                        last_edge = e;
                        outl_c++;
                        r.cls = CLS_OUTLIER;
                    end
                end else begin
                    sp = el / n;
                    sj = ares / n;
                    sh = jit_shift;
                    last_edge = e;
                    period_q = sp[47:0];
                    if (sj >= jitter_q) jitter_q = jitter_q + ((sj - jitter_q) >> sh);
                    else begin
                        d = jitter_q - sj;
                        lowb = d & ((64'd1 << sh) - 1);
                        jitter_q = jitter_q - ((d >> sh) + (lowb != 0 ? 1 : 0));
                    end
                    streak = 0;
                    acc_c++;
                    if (n > 1) begin
                        miss_c++;
                        mpulse_c = mpulse_c + n[31:0] - 1;
                        r.cls = CLS_MISSED;
                    end else r.cls = CLS_NORMAL;
                end
            end
        end
        r.period = period_q; r.jitter = jitter_q;
        r.acc = acc_c; r.spur = spur_c; r.miss = miss_c; r.mpulse = mpulse_c;
        r.outl = outl_c; r.stall = stall_c; r.resync = resync_c;
        return r;
    endfunction

    task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
        if (o_errors < 10)
            $display("mismatch %s: expected %0d actual %0d", what, exp_v, act_v);
        o_errors++;
    endtask

    t_edge_result got, want;
    bit bad;

    initial begin
        o_errors = 0;
        init_period = 48'(INIT_PERIOD_RST);
        gate_mult = GATE_MULT_RST; max_gap = MAX_GAP_RST;
        resync_thr = RESYNC_THR_RST; jit_shift = JITTER_SHIFT_RST;
        reseed_filter();
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            init_period = 48'(INIT_PERIOD_RST);
            gate_mult = GATE_MULT_RST; max_gap = MAX_GAP_RST;
            resync_thr = RESYNC_THR_RST; jit_shift = JITTER_SHIFT_RST;
            reseed_filter();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.taken  = i_m_tuser[0];
                got.cls    = i_m_tuser[4:1];
                got.period = i_m_tdata[47:0];
                got.jitter = i_m_tdata[95:48];
                got.revs   = i_m_tdata[99:96];
                got.acc    = i_m_tdata[131:100];
                got.spur   = i_m_tdata[163:132];
                got.miss   = i_m_tdata[195:164];
                got.mpulse = i_m_tdata[227:196];
                got.outl   = i_m_tdata[259:228];
                got.stall  = i_m_tdata[291:260];
                got.resync = i_m_tdata[323:292];
                if (expected_results.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result");
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.taken !== want.taken) report("edge_taken", want.taken, got.taken);
                    if (got.cls !== want.cls) report("edge_class", want.cls, got.cls);
                    if (got.period !== want.period) report("period", want.period, got.period);
                    if (got.jitter !== want.jitter) report("jitter", want.jitter, got.jitter);
                    if (got.revs !== want.revs) report("revs", want.revs, got.revs);
                    if (got.acc !== want.acc) report("accepted", want.acc, got.acc);
                    if (got.spur !== want.spur) report("spurious", want.spur, got.spur);
                    if (got.miss !== want.miss) report("missed", want.miss, got.miss);
                    if (got.mpulse !== want.mpulse) report("missed_sum", want.mpulse, got.mpulse);
                    if (got.outl !== want.outl) report("outlier", want.outl, got.outl);
                    if (got.stall !== want.stall) report("stall", want.stall, got.stall);
                    if (got.resync !== want.resync) report("resync", want.resync, got.resync);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_INIT_PERIOD: begin
                        init_period = i_cfg_data;
                        reseed_filter();
                    end
                    REG_GATE_MULT:    gate_mult  = i_cfg_data[3:0];
                    REG_MAX_GAP:      max_gap    = i_cfg_data[3:0];
                    REG_RESYNC_THR:   resync_thr = i_cfg_data[2:0];
                    REG_JITTER_SHIFT: jit_shift  = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(classify_edge(i_s_tdata));
        end
    end
endmodule

// File: sim/tb_hall_edge_period_gate_unit.sv
`timescale 1ns / 1ps
module tb_hall_edge_period_gate_unit;
    import hepg_pkg::*;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [47:0]  i_s_tdata = 0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [327:0] o_m_tdata;
    logic [4:0]   o_m_tuser;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = 0;
    logic [47:0]  i_cfg_data = 0;
    int           errors, pending;
    bit           calm;
    logic [47:0]  now_t;
    logic [47:0]  cur_period;

    hall_edge_period_gate_unit dut (.*);

    hepg_checker u_check (
        .i_clk, .i_rst_n, .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 13);
    end

    task automatic send_edge(logic [47:0] t);
        if (!calm && $urandom_range(99) < 13) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
            while (!calm && $urandom_range(99) < 13) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata  <= t;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic rotate(int count, logic [47:0] base);
        int kind;
        logic [47:0] jit;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(99);
            jit = 48'($urandom_range(32'(base / 16 + 1)));
            if (kind < 60) now_t = now_t + base + jit - base / 32;
            else if (kind < 72) now_t = now_t + base * 48'($urandom_range(4, 2)) + jit;
            else if (kind < 80) now_t = now_t + 48'($urandom_range(32'(base / 3 + 1)));
            else if (kind < 86) now_t = now_t + base * 48'($urandom_range(20, 9));
            else if (kind < 90) now_t = now_t - 48'($urandom_range(32'(base)));
            else if (kind < 95) now_t = now_t + base + base / 4 + jit;
            else now_t = 48'({$urandom, $urandom});
            send_edge(now_t);
        end
    endtask

    initial begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        calm = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed
        send_edge(48'd0);
        send_edge(48'd0);
        send_edge(48'd1000);
        send_edge(48'd2000);
        send_edge(48'd3010);
        send_edge(48'd5020);
        send_edge(48'd5200);
        send_edge(48'd6000);
        send_edge(48'd6900);
        send_edge(48'd50000);
        send_edge(48'd51000);
        send_edge(48'hFFFF_FFFF_FFFF);
        send_edge(48'd5);
        drain();
        write_reg(REG_GATE_MULT, 48'd0);
        write_reg(REG_MAX_GAP, 48'd15);
        write_reg(REG_RESYNC_THR, 48'd0);
        write_reg(REG_JITTER_SHIFT, 48'd7);
        write_reg(REG_INIT_PERIOD, 48'd0);
        send_edge(48'd10);
        send_edge(48'd11);
        send_edge(48'd12);
        send_edge(48'd20);
        send_edge(48'hFFFF_FFFF_FFFE);
        drain();
        write_reg(REG_GATE_MULT, 48'd15);
        write_reg(REG_MAX_GAP, 48'd1);
        write_reg(REG_RESYNC_THR, 48'd7);
        write_reg(REG_JITTER_SHIFT, 48'd0);
        write_reg(REG_INIT_PERIOD, 48'hFFFF_FFFF_FFFF);
        send_edge(48'd100);
        send_edge(48'd1100);
        send_edge(48'd2105);
        send_edge(48'd2300);
        drain();
        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            write_reg(REG_GATE_MULT, 48'($urandom_range(15, 1)));
            write_reg(REG_MAX_GAP, 48'($urandom_range(15, 1)));
            write_reg(REG_RESYNC_THR, 48'($urandom_range(7, 1)));
            write_reg(REG_JITTER_SHIFT, 48'($urandom_range(7)));
            cur_period = (ph == 7) ? 48'h7FFF_FFFF_FF : 48'($urandom_range(200000, 100));
            write_reg(REG_INIT_PERIOD, cur_period);
            now_t = 48'({$urandom, $urandom}) & 48'h0FFF_FFFF_FFFF;
            rotate(200, cur_period);
            drain();
        end
        calm = 0;
        drain();
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
